>>> hw/rtl/dqr_pkg.sv
// Shared types, constants and the answer record table for the DNS redirect responder.
package dqr_pkg;

	// Default depth of the command queue between front and back.
	localparam int unsigned QUEUE_DEPTH_DEF = 4;

	// Command kinds handed from the front to the back.
	localparam logic CMD_EMIT   = 1'b0;
	localparam logic CMD_ANSWER = 1'b1;

	// Number of bytes in the appended answer record.
	localparam int unsigned ANS_LEN = 16;
	localparam logic [3:0]  ANS_LAST = 4'(ANS_LEN - 1);

	// One command: a reply item, optionally followed by the answer record.
	typedef struct packed {
		logic       kind;
		logic [7:0] data;
		logic       last;
		logic       abort;
	} cmd_t;

	// Byte of the answer record at a given offset.
	function automatic logic [7:0] ans_byte(input logic [3:0] idx, input logic [31:0] addr);
		logic [7:0] b;
		case (idx)
			4'd0:    b = 8'hC0;
			4'd1:    b = 8'h0C;
			4'd2:    b = 8'h00;
			4'd3:    b = 8'h01;
			4'd4:    b = 8'h00;
			4'd5:    b = 8'h01;
			4'd6:    b = 8'h00;
			4'd7:    b = 8'h00;
			4'd8:    b = 8'h00;
			4'd9:    b = 8'd60;
			4'd10:   b = 8'h00;
			4'd11:   b = 8'h04;
			4'd12:   b = addr[31:24];
			4'd13:   b = addr[23:16];
			4'd14:   b = addr[15:8];
			4'd15:   b = addr[7:0];
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

>>> hw/rtl/dns_query_redirect_responder_core.sv
// Top level of the DNS redirect responder: parser, command queue and reply generator.
// Path: a reply item is written into the command queue when its query byte is taken and is
// then loaded into the output register, from which it is offered on the m_ side.
// Throughput: one query byte and one reply byte per cycle unless the queue is full or m_tready is
// low; the 16-byte answer record after the question holds the output while the queue fills.
// Reset: arst_n clears the parse state, queue pointers, output valid and the address register.
module dns_query_redirect_responder_core import dqr_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,    // [7:0] query_byte
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,    // [7:0] reply_byte
	output logic        m_tlast,
	output logic        m_tuser,    // [0] reply_abort
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);

	logic [31:0] answer_address_q;
	logic        push;
	cmd_t        push_cmd;
	logic        pop;
	cmd_t        pop_cmd;
	logic        q_empty;
	logic        q_full;

	// Address register for the answer record.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			answer_address_q <= 32'd0;
		end else if (cfg_valid) begin
			answer_address_q <= cfg_data;
		end
	end

	dqr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_byte  (s_tdata),
		.in_last  (s_tlast),
		.q_full   (q_full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	dqr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.empty    (q_empty),
		.full     (q_full)
	);

	dqr_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.answer_address (answer_address_q),
		.q_empty        (q_empty),
		.q_cmd          (pop_cmd),
		.pop            (pop),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready),
		.out_byte       (m_tdata),
		.out_last       (m_tlast),
		.out_abort      (m_tuser)
	);

`ifndef NO_ASSERTIONS
	// An abort item always closes its frame and carries a zero byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tlast && m_tdata == 8'h00))
		else $error("abort item without frame end or with nonzero data");

	// A normal frame ends only on the last octet of the answer address.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast && !m_tuser) |-> (m_tdata == answer_address_q[7:0]))
		else $error("reply frame ended outside the answer record");

	// The queue never takes a command while it is full.
	assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !push)
		else $error("command pushed into a full queue");
`endif

endmodule

>>> hw/rtl/dqr_front.sv
// Front end: parses query bytes and turns them into reply commands.
module dqr_front import dqr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	input  logic       q_full,
	output logic       push,
	output cmd_t       push_cmd
);

	localparam logic [2:0] PH_HEADER = 3'd0;
	localparam logic [2:0] PH_NAME   = 3'd1;
	localparam logic [2:0] PH_LABEL  = 3'd2;
	localparam logic [2:0] PH_TAIL   = 3'd3;
	localparam logic [2:0] PH_SKIP   = 3'd4;

	logic [2:0] phase_q, phase_d;
	logic [3:0] pos_q, pos_d;
	logic [7:0] lab_q, lab_d;
	logic       emit;
	logic       reject;
	logic       accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && !q_full;
	assign push     = accept && emit;

	// Classify the current byte and work out the next parse state.
	always_comb begin
		logic [7:0] ob;
		logic       bad;
		phase_d  = phase_q;
		pos_d    = pos_q;
		lab_d    = lab_q;
		emit     = 1'b0;
		reject   = 1'b0;
		ob       = in_byte;
		bad      = 1'b0;
		push_cmd = '{kind: CMD_EMIT, data: in_byte, last: 1'b0, abort: 1'b0};
		case (phase_q)
			PH_HEADER: begin
				case (pos_q)
					4'd2: begin
						bad = (in_byte & 8'hF8) != 8'h00;
						ob  = 8'h84;
					end
					4'd3: ob = 8'h00;
					4'd4: bad = in_byte != 8'h00;
					4'd5: bad = in_byte != 8'h01;
					4'd6: ob = 8'h00;
					4'd7: ob = 8'h01;
					default: ob = in_byte;
				endcase
				if (bad || in_last) begin
					reject = 1'b1;
				end else begin
					emit          = 1'b1;
					push_cmd.data = ob;
					if (pos_q == 4'd11) begin
						phase_d = PH_NAME;
						pos_d   = 4'd0;
					end else begin
						pos_d = pos_q + 4'd1;
					end
				end
			end
			PH_NAME: begin
				if (in_byte >= 8'hC0 || in_last) begin
					reject = 1'b1;
				end else begin
					emit = 1'b1;
					if (in_byte == 8'h00) begin
						phase_d = PH_TAIL;
						pos_d   = 4'd0;
					end else begin
						lab_d   = in_byte;
						phase_d = PH_LABEL;
					end
				end
			end
			PH_LABEL: begin
				if (in_last) begin
					reject = 1'b1;
				end else begin
					emit  = 1'b1;
					lab_d = lab_q - 8'd1;
					if (lab_q == 8'd1) begin
						phase_d = PH_NAME;
					end
				end
			end
			PH_TAIL: begin
				if (in_last && pos_q < 4'd3) begin
					reject = 1'b1;
				end else begin
					emit = 1'b1;
					if (pos_q == 4'd3) begin
						push_cmd.kind = CMD_ANSWER;
						phase_d       = in_last ? PH_HEADER : PH_SKIP;
						pos_d         = 4'd0;
						lab_d         = 8'd0;
					end else begin
						pos_d = pos_q + 4'd1;
					end
				end
			end
			default: begin
				if (in_last) begin
					phase_d = PH_HEADER;
					pos_d   = 4'd0;
					lab_d   = 8'd0;
				end
			end
		endcase
		// A rejected query ends its frame with an abort item.
		if (reject) begin
			emit     = 1'b1;
			push_cmd = '{kind: CMD_EMIT, data: 8'h00, last: 1'b1, abort: 1'b1};
			phase_d  = in_last ? PH_HEADER : PH_SKIP;
			pos_d    = 4'd0;
			lab_d    = 8'd0;
		end
	end

	// Parse state advances on every accepted byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			pos_q   <= 4'd0;
			lab_q   <= 8'd0;
		end else if (accept) begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			lab_q   <= lab_d;
		end
	end

endmodule

>>> hw/rtl/dqr_queue.sv
// Small command queue that decouples the parser from the reply generator.
module dqr_queue import dqr_pkg::*; #(
	parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output cmd_t pop_cmd,
	output logic empty,
	output logic full
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);

	cmd_t          mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign empty   = count_q == '0;
	assign full    = count_q == CW'(DEPTH);
	assign pop_cmd = mem_q[rd_ptr_q];

	// Storage is written at the write pointer.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

>>> hw/rtl/dqr_back.sv
// Back end: drains commands into the output register and appends the answer record.
module dqr_back import dqr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [31:0] answer_address,
	input  logic        q_empty,
	input  cmd_t        q_cmd,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        out_last,
	output logic        out_abort
);

	logic       valid_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic       abort_q;
	logic       burst_q;
	logic [3:0] idx_q;
	logic       load;

	assign load      = !valid_q || out_ready;
	assign pop       = load && !burst_q && !q_empty;
	assign out_valid = valid_q;
	assign out_byte  = byte_q;
	assign out_last  = last_q;
	assign out_abort = abort_q;

	// Output register is refilled from the answer burst first, else from the queue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			burst_q <= 1'b0;
			idx_q   <= 4'd0;
		end else if (load) begin
			if (burst_q) begin
				valid_q <= 1'b1;
				idx_q   <= idx_q + 4'd1;
				if (idx_q == ANS_LAST) begin
					burst_q <= 1'b0;
				end
			end else if (!q_empty) begin
				valid_q <= 1'b1;
				idx_q   <= 4'd0;
				burst_q <= q_cmd.kind == CMD_ANSWER;
			end else begin
				valid_q <= 1'b0;
			end
		end
	end

	// Payload of the output register.
	always_ff @(posedge clk) begin
		if (load) begin
			if (burst_q) begin
				byte_q  <= ans_byte(idx_q, answer_address);
				last_q  <= idx_q == ANS_LAST;
				abort_q <= 1'b0;
			end else begin
				byte_q  <= q_cmd.data;
				last_q  <= q_cmd.last;
				abort_q <= q_cmd.abort;
			end
		end
	end

endmodule
